// ----- sv/sltb_pkg.sv -----
// ----------------------------------------------------------------------------
// sltb_pkg
// Types and constants shared by the sorted label table builder.
// ----------------------------------------------------------------------------
package sltb_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Payload widths
  localparam int ID_W    = 64;
  localparam int KEY_W   = 32;
  localparam int COL_W   = 32;
  localparam int POS_W   = 16;
  localparam int FLAG_W  = 32;
  localparam int CHAN_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int CAP_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_CAPACITY = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET     = 6'd33;
  localparam logic [POS_W-1:0] POS_SATURATED = '1;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [COL_W-1:0]  colour;
    logic [POS_W-1:0]  position;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  // Settings handed from the register file to the core
  typedef struct packed {
    logic             signed_mode;
    logic [CNT_W-1:0] cap_m1;      // effective capacity less the header slot
  } cfg_t;

endpackage

// ----- sv/sltb_in_if.sv -----
// ----------------------------------------------------------------------------
// sltb_in_if
// Category record channel.
// ----------------------------------------------------------------------------
interface sltb_in_if
  import sltb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     has_category;
  logic signed [ID_W-1:0]   label_id;
  logic [CHAN_W-1:0]        red;
  logic [CHAN_W-1:0]        green;
  logic [CHAN_W-1:0]        blue;
  logic [CHAN_W-1:0]        alpha;
  logic [FLAG_W-1:0]        category_flags;
  logic                     last_category;

  modport source (
    output valid, has_category, label_id, red, green, blue, alpha,
           category_flags, last_category,
    input  ready
  );

  modport sink (
    input  valid, has_category, label_id, red, green, blue, alpha,
           category_flags, last_category,
    output ready
  );
endinterface

// ----- sv/sltb_out_if.sv -----
// ----------------------------------------------------------------------------
// sltb_out_if
// Table result channel: header and entries.
// ----------------------------------------------------------------------------
interface sltb_out_if
  import sltb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              is_header;
  logic [KEY_W-1:0]  entry_key;
  logic [COL_W-1:0]  entry_colour;
  logic [POS_W-1:0]  source_position;
  logic [FLAG_W-1:0] entry_flags;
  logic              overflow_error;
  logic              last_result;

  modport source (
    output valid, is_header, entry_key, entry_colour, source_position,
           entry_flags, overflow_error, last_result,
    input  ready
  );

  modport sink (
    input  valid, is_header, entry_key, entry_colour, source_position,
           entry_flags, overflow_error, last_result,
    output ready
  );
endinterface

// ----- sv/sltb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sltb_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface sltb_cfg_if
  import sltb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/sorted_label_table_builder.sv -----
// ----------------------------------------------------------------------------
// sorted_label_table_builder
// Builds a key-sorted category table and streams it out after each set.
// ----------------------------------------------------------------------------
// Usage:
//   rec  - category records, valid/ready. A record is taken only when the
//          block is idle; one record at a time.
//   res  - results, valid/ready, from an output register. After the set ends
//          a header (entry count, signed-mode flag) comes first, then every
//          entry in ascending key order; last_result marks the final one.
//   cfg  - register writes (index 0 signed_mode, 1 table_capacity), always
//          ready. Write only while no set is being emitted or inserted.
// Operation:
//   A stored record is accepted, then each entry with a larger key is moved
//   up one slot before the new entry is written. The entry memory has
//   one read and one write port, and each moved entry uses one of each.
//   A skipped record needs no memory access. Emission sends the header,
//   then each entry by a memory read and then an output load.
// Reset clears counts and registers; memory contents are not cleared.
// A stalled receiver holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module sorted_label_table_builder
  import sltb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sltb_in_if.sink     rec,
  sltb_out_if.source  res,
  sltb_cfg_if.sink    cfg
);

  cfg_t settings;

  // Register file
  sltb_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // Sort memory and sequencer
  sltb_core u_core (
    .clk      (clk),
    .rst      (rst),
    .settings (settings),
    .rec      (rec),
    .res      (res)
  );

endmodule

// ----- sv/sltb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sltb_cfg_regs
// Configuration registers with capacity clamping.
// ----------------------------------------------------------------------------
module sltb_cfg_regs
  import sltb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sltb_cfg_if.sink    cfg,
  output cfg_t        settings
);

  logic             signed_mode;
  logic [CAP_W-1:0] table_capacity;

  // Always ready to take a write request
  assign cfg.ready = 1'b1;

  // Capture register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode    <= 1'b0;
      table_capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SIGNED_MODE:    signed_mode    <= cfg.data[0];
        CFG_TABLE_CAPACITY: table_capacity <= cfg.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp capacity: zero acts as one, large values act as MAX_ENTRIES+1
  always_comb begin
    settings.signed_mode = signed_mode;
    if (table_capacity == '0) begin
      settings.cap_m1 = '0;
    end else if (int'(table_capacity) > MAX_ENTRIES + 1) begin
      settings.cap_m1 = CNT_W'(MAX_ENTRIES);
    end else begin
      settings.cap_m1 = CNT_W'(table_capacity - CAP_W'(1));
    end
  end

endmodule

// ----- sv/sltb_core.sv -----
// ----------------------------------------------------------------------------
// sltb_core
// Entry memory with insertion sort by shifting, and table readout.
// ----------------------------------------------------------------------------
module sltb_core
  import sltb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        settings,
  sltb_in_if.sink     rec,
  sltb_out_if.source  res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_HDR,
    S_RD,
    S_WAIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] in_pos;
  logic             ovf_seen;
  logic [IDX_W-1:0] j;
  entry_t           new_entry;
  logic             pend_emit;
  logic [CNT_W-1:0] e_idx;
  logic [CNT_W-1:0] e_cnt;

  // Entry memory, one read and one write port, registered read data
  entry_t           mem [MAX_ENTRIES];
  entry_t           rd_data;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  logic             accept;
  logic             fits;
  logic             full;
  logic             do_insert;
  logic             move_up;
  logic             slot_free;
  logic             e_last;
  logic             res_load;

  assign rec.ready = (state == S_IDLE);
  assign accept    = rec.valid && rec.ready;
  assign slot_free = !res.valid || res.ready;
  assign res_load  = ((state == S_HDR) || (state == S_WAIT)) && slot_free;

  // Key packing check: signed needs the upper 33 bits equal, unsigned needs zeros
  always_comb begin
    if (settings.signed_mode) begin
      fits = (&rec.label_id[ID_W-1:KEY_W-1]) || !(|rec.label_id[ID_W-1:KEY_W-1]);
    end else begin
      fits = !(|rec.label_id[ID_W-1:KEY_W]);
    end
  end

  assign full      = (count >= settings.cap_m1);
  assign do_insert = rec.has_category && !ovf_seen && !full && fits;
  assign move_up   = (j != '0) && (rd_data.key > new_entry.key);
  assign e_last    = ((e_idx + CNT_W'(1)) == e_cnt);

  // Memory port control
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = j;
    wdata = new_entry;
    case (state)
      S_IDLE: begin
        re    = accept && do_insert;
        raddr = IDX_W'(count - CNT_W'(1));
      end
      S_SHIFT: begin
        we = 1'b1;
        if (move_up) begin
          wdata = rd_data;
          re    = 1'b1;
          raddr = j - IDX_W'(2);
        end
      end
      S_RD: begin
        re    = 1'b1;
        raddr = e_idx[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // Sequencer: accept, shift entries up, then emit header and entries
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      in_pos    <= '0;
      ovf_seen  <= 1'b0;
      pend_emit <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !res_load) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!rec.has_category) begin
              state <= S_HDR;
            end else begin
              if (in_pos != POS_SATURATED) begin
                in_pos <= in_pos + POS_W'(1);
              end
              if (!ovf_seen && full) begin
                ovf_seen <= 1'b1;
              end
              if (do_insert) begin
                new_entry.key      <= rec.label_id[KEY_W-1:0];
                new_entry.colour   <= {rec.alpha, rec.blue, rec.green, rec.red};
                new_entry.position <= in_pos;
                new_entry.flags    <= rec.category_flags;
                j                  <= IDX_W'(count);
                pend_emit          <= rec.last_category;
                state              <= S_SHIFT;
              end else if (rec.last_category) begin
                state <= S_HDR;
              end
            end
          end
        end
        S_SHIFT: begin
          if (move_up) begin
            j <= j - IDX_W'(1);
          end else begin
            count <= count + CNT_W'(1);
            state <= pend_emit ? S_HDR : S_IDLE;
          end
        end
        S_HDR: begin
          if (slot_free) begin
            res.valid           <= 1'b1;
            res.is_header       <= 1'b1;
            res.entry_key       <= ovf_seen ? '0 : KEY_W'(count);
            res.entry_colour    <= '0;
            res.source_position <= '0;
            res.entry_flags     <= FLAG_W'(settings.signed_mode);
            res.overflow_error  <= ovf_seen;
            res.last_result     <= ovf_seen || (count == '0);
            e_cnt               <= count;
            e_idx               <= '0;
            count               <= '0;
            in_pos              <= '0;
            ovf_seen            <= 1'b0;
            state               <= (ovf_seen || count == '0) ? S_IDLE : S_RD;
          end
        end
        S_RD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (slot_free) begin
            res.valid           <= 1'b1;
            res.is_header       <= 1'b0;
            res.entry_key       <= rd_data.key;
            res.entry_colour    <= rd_data.colour;
            res.source_position <= rd_data.position;
            res.entry_flags     <= rd_data.flags;
            res.overflow_error  <= 1'b0;
            res.last_result     <= e_last;
            e_idx               <= e_idx + CNT_W'(1);
            state               <= e_last ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/sltb_checker.sv -----
// ----------------------------------------------------------------------------
// sltb_checker
// Port-level checks for the sorted label table builder.
// ----------------------------------------------------------------------------
module sltb_checker
  import sltb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rec_valid,
  input logic              rec_ready,
  input logic              rec_has_category,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_is_header,
  input logic [KEY_W-1:0]  res_entry_key,
  input logic              res_overflow_error,
  input logic              res_last_result
);

  // Hold a stalled result request
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_entry_key)
      && $stable(res_is_header) && $stable(res_last_result))
    else $error("stalled result changed");

  // An aborted set is a single header
  a_ovf_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_header && res_overflow_error |-> res_last_result)
    else $error("overflow header not final");

  // Overflow is reported only in headers
  a_ovf_hdr: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_is_header |-> !res_overflow_error)
    else $error("overflow flag on entry");

  // Header count never exceeds the table depth
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_header |-> res_entry_key <= KEY_W'(MAX_ENTRIES))
    else $error("header count too large");

  // An end marker starts emission, so no record is taken next cycle
  a_marker_busy: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready && !rec_has_category |=> !rec_ready)
    else $error("record taken during emission");

endmodule

bind sorted_label_table_builder sltb_checker u_sltb_checker (
  .clk                (clk),
  .rst                (rst),
  .rec_valid          (rec.valid),
  .rec_ready          (rec.ready),
  .rec_has_category   (rec.has_category),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_is_header      (res.is_header),
  .res_entry_key      (res.entry_key),
  .res_overflow_error (res.overflow_error),
  .res_last_result    (res.last_result)
);

// ----- test/sltb_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sltb_table_checker
// Watches the record, result and register channels of the table builder,
// keeps its own sorted copy of the table and checks every emitted row.
// ----------------------------------------------------------------------------
module sltb_table_checker
  import sltb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sltb_in_if   rec,
  sltb_out_if  res,
  sltb_cfg_if  cfg,
  output int   fail_count,
  output int   rows_pending
);

  localparam logic signed [ID_W-1:0] SIGNED_KEY_MIN   = -64'sd2147483648;
  localparam logic signed [ID_W-1:0] SIGNED_KEY_MAX   = 64'sd2147483647;
  localparam logic signed [ID_W-1:0] UNSIGNED_KEY_MAX = 64'sd4294967295;

  typedef struct packed {
    logic              is_header;
    logic [KEY_W-1:0]  key;
    logic [COL_W-1:0]  colour;
    logic [POS_W-1:0]  position;
    logic [FLAG_W-1:0] flags;
    logic              overflow;
    logic              last;
  } table_row_t;

  // Shadow of the block's table and registers
  entry_t           sorted_entries [MAX_ENTRIES];
  int unsigned      shadow_count;
  logic [POS_W-1:0] next_position;
  logic             set_aborted;
  logic             shadow_signed;
  logic [CAP_W-1:0] capacity_reg;
  table_row_t       expected_rows [$];

  function automatic logic id_fits(logic signed [ID_W-1:0] id);
    if (shadow_signed)
      return (id >= SIGNED_KEY_MIN) && (id <= SIGNED_KEY_MAX);
    return (id >= 0) && (id <= UNSIGNED_KEY_MAX);
  endfunction

  // Insert the current request into the shadow table, keeping it stable
  task automatic absorb_record();
    int unsigned      room;
    int unsigned      slot;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    room = (capacity_reg == '0) ? 1 : int'(capacity_reg);
    if (room > MAX_ENTRIES + 1)
      room = MAX_ENTRIES + 1;
    room = room - 1;
    pos = next_position;
    if (next_position != POS_SATURATED)
      next_position = next_position + POS_W'(1);
    if (set_aborted)
      return;
    // abort before looking at the id: even a skipped record overflows
    if (shadow_count >= room) begin
      set_aborted = 1'b1;
      return;
    end
    if (!id_fits(rec.label_id))
      return;
    key  = rec.label_id[KEY_W-1:0];
    slot = shadow_count;
    while (slot > 0 && sorted_entries[IDX_W'(slot - 1)].key > key) begin
      sorted_entries[IDX_W'(slot)] = sorted_entries[IDX_W'(slot - 1)];
      slot--;
    end
    sorted_entries[IDX_W'(slot)].key      = key;
    sorted_entries[IDX_W'(slot)].colour   = {rec.alpha, rec.blue, rec.green, rec.red};
    sorted_entries[IDX_W'(slot)].position = pos;
    sorted_entries[IDX_W'(slot)].flags    = rec.category_flags;
    shadow_count++;
  endtask

  // Queue the header and entries of the finished set, then clear the set
  task automatic emit_table();
    table_row_t row;
    row.is_header = 1'b1;
    row.colour    = '0;
    row.position  = '0;
    row.flags     = {{(FLAG_W-1){1'b0}}, shadow_signed};
    row.overflow  = set_aborted;
    row.key       = set_aborted ? '0 : KEY_W'(shadow_count);
    row.last      = set_aborted || (shadow_count == 0);
    expected_rows.push_back(row);
    if (!set_aborted) begin
      for (int i = 0; i < shadow_count; i++) begin
        row.is_header = 1'b0;
        row.key       = sorted_entries[IDX_W'(i)].key;
        row.colour    = sorted_entries[IDX_W'(i)].colour;
        row.position  = sorted_entries[IDX_W'(i)].position;
        row.flags     = sorted_entries[IDX_W'(i)].flags;
        row.overflow  = 1'b0;
        row.last      = (i + 1 == shadow_count);
        expected_rows.push_back(row);
      end
    end
    shadow_count  = 0;
    next_position = '0;
    set_aborted   = 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Check one accepted result against the oldest expected row
  task automatic match_result();
    table_row_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual key %h header %b",
               $time, res.entry_key, res.is_header);
      fail_count++;
      return;
    end
    want = expected_rows.pop_front();
    compare_field("is_header", 32'(want.is_header), 32'(res.is_header));
    compare_field("entry_key", want.key, res.entry_key);
    compare_field("entry_colour", want.colour, res.entry_colour);
    compare_field("source_position", 32'(want.position), 32'(res.source_position));
    compare_field("entry_flags", want.flags, res.entry_flags);
    compare_field("overflow_error", 32'(want.overflow), 32'(res.overflow_error));
    compare_field("last_result", 32'(want.last), 32'(res.last_result));
  endtask

  // Follow every request on the three channels
  always @(posedge clk) begin
    if (rst) begin
      shadow_count  = 0;
      next_position = '0;
      set_aborted   = 1'b0;
      shadow_signed = 1'b0;
      capacity_reg  = CAP_RESET;
      fail_count    = 0;
      rows_pending  = 0;
      expected_rows.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SIGNED_MODE:    shadow_signed = cfg.data[0];
          CFG_TABLE_CAPACITY: capacity_reg  = cfg.data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (rec.valid && rec.ready) begin
        if (!rec.has_category) begin
          emit_table();
        end else begin
          absorb_record();
          if (rec.last_category)
            emit_table();
        end
      end
      if (res.valid && res.ready)
        match_result();
      rows_pending = expected_rows.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives category sets into the sorted table builder: directed corner sets,
// then random sets under random register settings and random back-pressure.
// The checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import sltb_pkg::*;

  localparam int SETTLE_CYCLES  = 40;    // longest insertion plus margin
  localparam int DRAIN_CYCLES   = 80;
  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_RECORDS = 16;

  typedef struct packed {
    logic              has_category;
    logic [ID_W-1:0]   id;
    logic [COL_W-1:0]  colour;
    logic [FLAG_W-1:0] flags;
    logic              last_category;
  } cat_rec_t;

  logic     clk;
  logic     rst;
  int       fail_count;
  int       rows_pending;
  bit       pace_records;
  cat_rec_t batch [$];

  sltb_in_if  rec();
  sltb_out_if res();
  sltb_cfg_if cfg();

  sorted_label_table_builder i_dut (
    .clk (clk),
    .rst (rst),
    .rec (rec),
    .res (res),
    .cfg (cfg)
  );

  sltb_table_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .rec          (rec),
    .res          (res),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Favor small ids for equal keys, plus range edges and wide noise
  function automatic logic [ID_W-1:0] pick_id();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(9))
      0, 1, 2: return 64'(longint'($urandom_range(0, 9)) - 3);
      3, 4:    return {32'h0, word};
      5:       return {{32{word[31]}}, word};
      6, 7: begin
        case ($urandom_range(9))
          0: return 64'h0;
          1: return 64'h0000_0000_FFFF_FFFF;
          2: return 64'h0000_0001_0000_0000;
          3: return 64'hFFFF_FFFF_FFFF_FFFF;
          4: return 64'hFFFF_FFFF_8000_0000;
          5: return 64'h0000_0000_7FFF_FFFF;
          6: return 64'h0000_0000_8000_0000;
          7: return 64'hFFFF_FFFF_7FFF_FFFF;
          8: return 64'h8000_0000_0000_0000;
          default: return 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cat_rec_t record_of(logic [ID_W-1:0] id, logic [COL_W-1:0] colour,
                                         logic [FLAG_W-1:0] flags, logic last);
    cat_rec_t r;
    r.has_category  = 1'b1;
    r.id            = id;
    r.colour        = colour;
    r.flags         = flags;
    r.last_category = last;
    return r;
  endfunction

  // End-of-set marker; its other fields carry noise
  function automatic cat_rec_t make_marker();
    cat_rec_t r;
    r = record_of({$urandom, $urandom}, $urandom, $urandom, 1'($urandom_range(1)));
    r.has_category = 1'b0;
    return r;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_record(cat_rec_t r);
    int unsigned gap;
    rec.valid          <= 1'b1;
    rec.has_category   <= r.has_category;
    rec.label_id       <= r.id;
    rec.red            <= r.colour[7:0];
    rec.green          <= r.colour[15:8];
    rec.blue           <= r.colour[23:16];
    rec.alpha          <= r.colour[31:24];
    rec.category_flags <= r.flags;
    rec.last_category  <= r.last_category;
    do @(posedge clk); while (rec.ready !== 1'b1);
    if (pace_records) begin
      gap = draw_gap();
      if (gap != 0) begin
        rec.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_batch();
    foreach (batch[i])
      send_record(batch[i]);
    rec.valid <= 1'b0;
    batch.delete();
  endtask

  // Wait for all rows, then let the block finish any trailing work
  task automatic await_idle();
    @(posedge clk);
    while (rows_pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side back-pressure, with steady stretches now and then
  initial begin : drain_pacing
    int unsigned gap;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      res.ready <= 1'b1;
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 6)) @(posedge clk);
      gap = draw_gap();
      if (gap != 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // End the run when no request moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((rec.valid && rec.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          records_random;
    int unsigned n;
    int unsigned kind;
    logic [5:0]  capacity;

    rst                <= 1'b1;
    rec.valid          <= 1'b0;
    rec.has_category   <= 1'b0;
    rec.label_id       <= '0;
    rec.red            <= '0;
    rec.green          <= '0;
    rec.blue           <= '0;
    rec.alpha          <= '0;
    rec.category_flags <= '0;
    rec.last_category  <= 1'b0;
    cfg.valid          <= 1'b0;
    cfg.index          <= CFG_SIGNED_MODE;
    cfg.data           <= '0;
    pace_records        = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Unsigned keys at reset settings: edges, skips, equal keys kept in order
    batch.push_back(record_of(64'd5, 32'h0000_0000, 32'h0000_0000, 1'b0));
    batch.push_back(record_of(64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    batch.push_back(record_of(64'h0000_0001_0000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd0, 32'h4433_2211, 32'hA5A5_A5A5, 1'b0));
    batch.push_back(record_of(64'd5, 32'h1122_3344, 32'h5A5A_5A5A, 1'b0));
    batch.push_back(record_of(64'h8000_0000_0000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'h7FFF_FFFF_FFFF_FFFF, $urandom, $urandom, 1'b1));
    // Empty set, then a set closed by a marker
    batch.push_back(make_marker());
    batch.push_back(record_of(64'd7, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd3, $urandom, $urandom, 1'b0));
    batch.push_back(make_marker());
    send_batch();

    // Signed keys: int32 edges fit, one past either edge is skipped
    await_idle();
    write_register(CFG_SIGNED_MODE, 6'd1);
    batch.push_back(record_of(64'hFFFF_FFFF_8000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'h0000_0000_7FFF_FFFF, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'h0000_0000_8000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'hFFFF_FFFF_7FFF_FFFF, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd0, $urandom, $urandom, 1'b1));
    send_batch();

    // Capacity one: the header slot alone, every record overflows
    await_idle();
    write_register(CFG_TABLE_CAPACITY, 6'd1);
    batch.push_back(record_of(64'd1, $urandom, $urandom, 1'b1));
    send_batch();

    // Capacity zero acts as one; a skipped id still overflows
    await_idle();
    write_register(CFG_TABLE_CAPACITY, 6'd0);
    batch.push_back(record_of(64'h0000_0100_0000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd1, $urandom, $urandom, 1'b1));
    send_batch();

    // Capacity three: third record aborts, the rest of the set is dropped
    await_idle();
    write_register(CFG_TABLE_CAPACITY, 6'd3);
    write_register(CFG_SIGNED_MODE, 6'd0);
    batch.push_back(record_of(64'd9, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd8, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd7, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd6, $urandom, $urandom, 1'b1));
    send_batch();

    // Capacity above range acts as the full table
    await_idle();
    write_register(CFG_TABLE_CAPACITY, 6'd63);
    batch.push_back(record_of(64'd2, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'h0000_0002_0000_0000, $urandom, $urandom, 1'b0));
    batch.push_back(record_of(64'd1, $urandom, $urandom, 1'b1));
    send_batch();

    // Full table, then one record too many
    await_idle();
    write_register(CFG_TABLE_CAPACITY, 6'd33);
    for (int i = 0; i < MAX_ENTRIES; i++)
      batch.push_back(record_of({32'h0, $urandom}, $urandom, $urandom, i == MAX_ENTRIES - 1));
    send_batch();
    for (int i = 0; i <= MAX_ENTRIES; i++)
      batch.push_back(record_of({32'h0, $urandom}, $urandom, $urandom, i == MAX_ENTRIES));
    send_batch();

    // Random sets under random settings
    records_random = 0;
    while (records_random < RANDOM_RECORDS) begin
      if ($urandom_range(99) < 35) begin
        kind = $urandom_range(99);
        if (kind < 50)      capacity = 6'd33;
        else if (kind < 65) capacity = 6'($urandom_range(2, 10));
        else if (kind < 75) capacity = 6'($urandom_range(11, 32));
        else if (kind < 82) capacity = 6'd1;
        else if (kind < 88) capacity = 6'd0;
        else if (kind < 94) capacity = 6'($urandom_range(34, 63));
        else                capacity = 6'd2;
        await_idle();
        write_register(CFG_SIGNED_MODE, 6'($urandom_range(1)));
        write_register(CFG_TABLE_CAPACITY, capacity);
      end
      pace_records = ($urandom_range(99) >= 20);
      kind = $urandom_range(99);
      if (kind < 8)       n = 0;
      else if (kind < 75) n = $urandom_range(1, 6);
      else if (kind < 93) n = $urandom_range(7, 14);
      else                n = $urandom_range(20, 34);
      for (int i = 0; i < n; i++)
        batch.push_back(record_of(pick_id(), $urandom, $urandom, 1'b0));
      if (n != 0 && $urandom_range(99) < 80)
        batch[n-1].last_category = 1'b1;
      else
        batch.push_back(make_marker());
      records_random += batch.size();
      send_batch();
    end
    pace_records = 1'b1;

    // Drain outstanding rows, then give the verdict
    @(posedge clk);
    while (rows_pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
